[design/sample_history_moving_average_core_macros.svh]
// Assertion macros shared by the moving average RTL files.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef SAMPLE_HISTORY_MOVING_AVERAGE_CORE_MACROS_SVH
`define SAMPLE_HISTORY_MOVING_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SHMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/shma_pkg.sv]
// Package for the sample history moving average block: field widths,
// register map constants and the divider control struct. No dependencies.
`default_nettype none

package shma_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int AGE_W          = 6;
  localparam int WS_W           = 7;
  localparam int DIFF_W         = 17;
  localparam int DEF_MAX_WINDOW = 64;

  localparam logic [WS_W-1:0] WS_RESET = 7'd16;

  // APB register map: one register at byte address 0
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_WINDOW_SIZE = '0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic            start;
    logic [WS_W-1:0] divisor;
  } div_ctl_t;

endpackage

`default_nettype wire

[design/shma_in_if.sv]
// Input channel of the moving average block: valid/ready plus one sample
// and its read-back age. Depends on shma_pkg.
`default_nettype none

interface shma_in_if;
  import shma_pkg::*;

  logic               valid;
  logic               ready;
  sample_t            sample;
  logic [AGE_W-1:0]   lookback_age;

  modport source (output valid, output sample, output lookback_age, input ready);
  modport sink (input valid, input sample, input lookback_age, output ready);
endinterface

`default_nettype wire

[design/shma_out_if.sv]
// Result channel of the moving average block: valid/ready plus mean,
// window difference and aged sample. Depends on shma_pkg.
`default_nettype none

interface shma_out_if;
  import shma_pkg::*;

  logic                      valid;
  logic                      ready;
  sample_t                   window_mean;
  logic signed [DIFF_W-1:0]  latest_minus_oldest;
  sample_t                   aged_sample;

  modport source (output valid, output window_mean, output latest_minus_oldest,
                  output aged_sample, input ready);
  modport sink (input valid, input window_mean, input latest_minus_oldest,
                input aged_sample, output ready);
endinterface

`default_nettype wire

[design/shma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module shma_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[design/shma_div.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on shma_pkg and the assertion macros.
`default_nettype none
`include "sample_history_moving_average_core_macros.svh"

module shma_div #(
  parameter int SUM_W = 22
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire shma_pkg::div_ctl_t      ctl,
  input  wire logic signed [SUM_W-1:0] dividend,
  output logic                         done,
  output shma_pkg::sample_t            quotient
);
  import shma_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] mag_r, mag_nxt;
  logic [WS_W:0]    rem_r, rem_nxt;
  logic [WS_W-1:0]  div_r, div_nxt;
  logic             neg_r, neg_nxt;

  logic [WS_W:0]    rem_sh;
  logic             ge;
  logic [SUM_W-1:0] q_signed;

  assign rem_sh = {rem_r[WS_W-1:0], mag_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[SUM_W-1];
      mag_nxt  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      div_nxt  = ctl.divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt = ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
      mag_nxt = {mag_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign q_signed = neg_r ? (~mag_r + 1'b1) : mag_r;
  assign quotient = q_signed[SAMPLE_W-1:0];
  assign done     = done_r;

  `SHMA_ASSERT_IMP(a_start_idle, ctl.start, !busy_r, "divider started while busy")
  `SHMA_ASSERT_NXT(a_done_pulse, done_r, !done_r && !busy_r, "done not a single pulse")
  `SHMA_ASSERT_IMP(a_cnt_range, busy_r, cnt_r <= CNT_W'(SUM_W - 1), "iteration count overrun")

endmodule

`default_nettype wire

[design/sample_history_moving_average_core.sv]
// Top level of the sample history moving average block: APB register,
// sequencer, ring RAM and divider. Depends on shma_pkg, the channel
// interfaces, shma_ram, shma_div and the assertion macros.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-----------------------------------------
//  in_if    | sink      | valid/ready      | sample, lookback_age
//  out_if   | source    | valid/ready      | window_mean, latest_minus_oldest, aged_sample
//  APB      | slave     | psel/penable     | window_size at byte address 0
//
// After the in transfer each item reads the old, oldest and aged entries from the RAM,
// then waits on the bit-serial divider for the mean, one bit per cycle.
// Reset and each window_size write clear the history at once through a fill count.
// The result holds in its output register until the out transfer; in_if.ready stays low
// from the in transfer until then.
`default_nettype none
`include "sample_history_moving_average_core_macros.svh"

module sample_history_moving_average_core #(
  parameter int MAX_WINDOW = shma_pkg::DEF_MAX_WINDOW
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [shma_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [shma_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [shma_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  shma_in_if.sink                              in_if,
  shma_out_if.source                           out_if
);
  import shma_pkg::*;

  localparam int POS_W = $clog2(MAX_WINDOW);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int IDX_W = ((POS_W > WS_W) ? POS_W : WS_W) + 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_RD_OLD    = 3'd1;
  localparam logic [2:0] S_UPD       = 3'd2;
  localparam logic [2:0] S_RD_OLDEST = 3'd3;
  localparam logic [2:0] S_RD_AGED   = 3'd4;
  localparam logic [2:0] S_WAIT      = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [WS_W-1:0]          ws_r, ws_nxt;
  logic [POS_W-1:0]         latest_r, latest_nxt;
  logic [WS_W-1:0]          fill_r, fill_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  sample_t                  sample_r, sample_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [POS_W-1:0]         oldest_r, oldest_nxt;
  logic [POS_W-1:0]         aged_idx_r, aged_idx_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  sample_t                  aged_r, aged_nxt;
  sample_t                  mean_r, mean_nxt;

  logic [WS_W-1:0]  n_eff;
  logic [IDX_W-1:0] n_ext, pos_inc, pos_calc, oldest_inc, oldest_calc;
  logic [IDX_W-1:0] age_ext, age_sat, aged_calc;

  logic             cfg_wr;
  logic             in_fire;
  logic             ram_wr_en, ram_rd_en;
  logic [POS_W-1:0] ram_rd_addr;
  sample_t          ram_rd_data;
  sample_t          ram_val;
  div_ctl_t         div_ctl;
  logic             div_done;
  sample_t          div_q;

  // An entry never written since the last clear reads as zero. Writes run
  // 1, 2, .., n-1, 0 after a clear, so the fill count tells which are live.
  function automatic logic entry_valid(input logic [POS_W-1:0] idx,
                                       input logic [WS_W-1:0]  fill,
                                       input logic [WS_W-1:0]  n);
    logic ok;
    if (idx == '0) begin
      ok = (fill == n);
    end else begin
      ok = (IDX_W'(idx) <= IDX_W'(fill));
    end
    return ok;
  endfunction

  assign n_eff = (ws_r == '0) ? WS_W'(1) :
                 ((int'(ws_r) > MAX_WINDOW) ? WS_W'(MAX_WINDOW) : ws_r);

  // Ring indexes for the next item
  assign n_ext       = IDX_W'(n_eff);
  assign pos_inc     = IDX_W'(latest_r) + 1'b1;
  assign pos_calc    = (pos_inc == n_ext) ? '0 : pos_inc;
  assign oldest_inc  = pos_calc + 1'b1;
  assign oldest_calc = (oldest_inc == n_ext) ? '0 : oldest_inc;
  assign age_ext     = IDX_W'(in_if.lookback_age);
  assign age_sat     = (age_ext > n_ext - 1'b1) ? (n_ext - 1'b1) : age_ext;
  assign aged_calc   = (pos_calc >= age_sat) ? (pos_calc - age_sat)
                                             : (pos_calc + n_ext - age_sat);

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_SIZE);
  assign prdata  = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_SIZE) ? CFG_DATA_W'(ws_r) : '0;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  always_comb begin
    state_nxt    = state_r;
    ws_nxt       = ws_r;
    latest_nxt   = latest_r;
    fill_nxt     = fill_r;
    sum_nxt      = sum_r;
    sample_nxt   = sample_r;
    pos_nxt      = pos_r;
    oldest_nxt   = oldest_r;
    aged_idx_nxt = aged_idx_r;
    diff_nxt     = diff_r;
    aged_nxt     = aged_r;
    mean_nxt     = mean_r;
    ram_wr_en    = 1'b0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = pos_r;
    ram_val      = '0;
    div_ctl.start   = 1'b0;
    div_ctl.divisor = n_eff;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sample_nxt   = in_if.sample;
          pos_nxt      = pos_calc[POS_W-1:0];
          oldest_nxt   = oldest_calc[POS_W-1:0];
          aged_idx_nxt = aged_calc[POS_W-1:0];
          state_nxt    = S_RD_OLD;
        end
      end
      S_RD_OLD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pos_r;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        // replace the entry at pos and launch the mean
        ram_val       = entry_valid(pos_r, fill_r, n_eff) ? ram_rd_data : '0;
        sum_nxt       = sum_r + SUM_W'(sample_r) - SUM_W'(ram_val);
        ram_wr_en     = 1'b1;
        latest_nxt    = pos_r;
        fill_nxt      = (fill_r == n_eff) ? fill_r : (fill_r + 1'b1);
        div_ctl.start = 1'b1;
        ram_rd_en     = 1'b1;
        ram_rd_addr   = oldest_r;
        state_nxt     = S_RD_OLDEST;
      end
      S_RD_OLDEST: begin
        // a window of one reads back the entry just written
        if (oldest_r == pos_r) begin
          ram_val = sample_r;
        end else begin
          ram_val = entry_valid(oldest_r, fill_r, n_eff) ? ram_rd_data : '0;
        end
        diff_nxt    = DIFF_W'(sample_r) - DIFF_W'(ram_val);
        ram_rd_en   = 1'b1;
        ram_rd_addr = aged_idx_r;
        state_nxt   = S_RD_AGED;
      end
      S_RD_AGED: begin
        aged_nxt  = entry_valid(aged_idx_r, fill_r, n_eff) ? ram_rd_data : '0;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          mean_nxt  = div_q;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_if.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a window_size write restarts the history
    if (cfg_wr) begin
      ws_nxt     = pwdata[WS_W-1:0];
      latest_nxt = '0;
      fill_nxt   = '0;
      sum_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ws_r     <= WS_RESET;
      latest_r <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ws_r     <= ws_nxt;
      latest_r <= latest_nxt;
      fill_r   <= fill_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    pos_r      <= pos_nxt;
    oldest_r   <= oldest_nxt;
    aged_idx_r <= aged_idx_nxt;
    diff_r     <= diff_nxt;
    aged_r     <= aged_nxt;
    mean_r     <= mean_nxt;
  end

  shma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (pos_r),
    .wr_data (sample_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  shma_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (sum_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_if.valid               = (state_r == S_OUT);
  assign out_if.window_mean         = mean_r;
  assign out_if.latest_minus_oldest = diff_r;
  assign out_if.aged_sample         = aged_r;

  `SHMA_ASSERT_IMP(a_no_overlap, out_if.valid, !in_if.ready, "input taken while result pending")
  `SHMA_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= n_eff, "fill count beyond window")
  `SHMA_ASSERT_IMP(a_latest_bound, 1'b1, IDX_W'(latest_r) < n_ext, "latest position outside window")
  `SHMA_ASSERT_IMP(a_div_done_wait, div_done, state_r == S_WAIT, "divider finished out of sequence")
  `SHMA_ASSERT_NXT(a_fire_read, in_fire, state_r == S_RD_OLD, "transfer did not start ring read")

endmodule

`default_nettype wire
